[hw/rtl/sdiv_pkg.sv]
// Shared types for the signed restoring divider.
`timescale 1ns / 1ps

package sdiv_pkg;

  // Control that travels alongside each word through the division row.
  typedef struct packed {
    logic valid;  // stage holds a live word
    logic neg;    // operand signs differ, so the quotient is negated
    logic sat;    // zero divisor or overflowing pair: force the largest positive value
  } sdiv_ctl_t;

endpackage

[hw/rtl/sdiv_in_if.sv]
// Operand channel: valid/ready handshake carrying dividend and divisor.
`timescale 1ns / 1ps

interface sdiv_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [DATA_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

[hw/rtl/sdiv_out_if.sv]
// Result channel: valid/ready handshake carrying the quotient.
`timescale 1ns / 1ps

interface sdiv_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

[hw/rtl/sdiv_prep.sv]
// Entry stage: strips operand signs and flags the saturating cases.
`timescale 1ns / 1ps

module sdiv_prep #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] num_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  output sdiv_pkg::sdiv_ctl_t   ctl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] dmag_o
);
  import sdiv_pkg::*;

  localparam logic [DATA_WIDTH-1:0] SignBit = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] AllOnes = {DATA_WIDTH{1'b1}};
  localparam logic [DATA_WIDTH-1:0] One     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  sdiv_ctl_t             ctl_r, ctl_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] dmag_r, dmag_nxt;

  // Magnitudes and the special-case flags.
  always_comb begin
    ctl_nxt.valid = valid_i;
    ctl_nxt.neg   = num_i[DATA_WIDTH-1] ^ den_i[DATA_WIDTH-1];
    ctl_nxt.sat   = (den_i == '0) || ((num_i == SignBit) && (den_i == AllOnes));
    rem_nxt       = num_i[DATA_WIDTH-1] ? (~num_i + One) : num_i;
    dmag_nxt      = den_i[DATA_WIDTH-1] ? (~den_i + One) : den_i;
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  // Data register.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      dmag_r <= dmag_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign dmag_o = dmag_r;
endmodule

[hw/rtl/sdiv_cell.sv]
// One restoring division step: decides one quotient bit and updates the remainder.
`timescale 1ns / 1ps

module sdiv_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int SHIFT      = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  sdiv_pkg::sdiv_ctl_t   ctl_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] quo_i,
  input  logic [DATA_WIDTH-1:0] dmag_i,
  output sdiv_pkg::sdiv_ctl_t   ctl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic [DATA_WIDTH-1:0] dmag_o
);
  import sdiv_pkg::*;

  sdiv_ctl_t             ctl_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dmag_r;
  logic [DATA_WIDTH-1:0] rem_shr;
  logic                  fits;

  // Trial subtraction of the divisor aligned to this bit position.
  always_comb begin
    rem_shr = rem_i >> SHIFT;
    fits    = (rem_shr >= dmag_i);
    rem_nxt = fits ? (rem_i - (dmag_i << SHIFT)) : rem_i;
    quo_nxt = quo_i | ({{(DATA_WIDTH-1){1'b0}}, fits} << SHIFT);
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  // Data registers handed to the next cell.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      dmag_r <= dmag_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign dmag_o = dmag_r;
endmodule

[hw/rtl/sdiv_fix.sv]
// Exit stage: applies the sign or saturation and holds the result word.
`timescale 1ns / 1ps

module sdiv_fix #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  sdiv_pkg::sdiv_ctl_t   ctl_i,
  input  logic [DATA_WIDTH-1:0] quo_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] quo_o
);
  import sdiv_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] One    = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;

  // A magnitude of exactly the sign bit negates to itself, so it needs no case of its own.
  always_comb begin
    if (ctl_i.sat) begin
      quo_nxt = MaxPos;
    end else if (ctl_i.neg) begin
      quo_nxt = ~quo_i + One;
    end else begin
      quo_nxt = quo_i;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= ctl_i.valid;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r <= quo_nxt;
    end
  end

  assign valid_o = valid_r;
  assign quo_o   = quo_r;
endmodule

[hw/rtl/signed_restoring_divider_core.sv]
// Top level of the pipelined signed restoring divider.
// Stages: entry stage, one cell per quotient bit, then the output register, between an
// accepted word and its quotient.
// Throughput: one word per cycle; the whole row advances whenever the output register
// is empty or being taken, so a stall on the result side holds every stage.
// Reset: synchronous, active low; clears every stage's valid flag, data is not reset.
`timescale 1ns / 1ps

module signed_restoring_divider_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sdiv_in_if.sink    in_ch,
  sdiv_out_if.source out_ch
);
  import sdiv_pkg::*;

  logic                  adv;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_quo;

  sdiv_ctl_t             ctl_c  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_c  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] quo_c  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dmag_c [0:DATA_WIDTH];

  // Global advance: the row moves when the output register can take a word.
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  sdiv_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .valid_i(in_ch.valid),
    .num_i  (in_ch.numerator),
    .den_i  (in_ch.denominator),
    .ctl_o  (ctl_c[0]),
    .rem_o  (rem_c[0]),
    .dmag_o (dmag_c[0])
  );

  assign quo_c[0] = '0;

  // One cell per quotient bit, top bit first.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    sdiv_cell #(.DATA_WIDTH(DATA_WIDTH), .SHIFT(DATA_WIDTH - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_c[k]),
      .rem_i (rem_c[k]),
      .quo_i (quo_c[k]),
      .dmag_i(dmag_c[k]),
      .ctl_o (ctl_c[k+1]),
      .rem_o (rem_c[k+1]),
      .quo_o (quo_c[k+1]),
      .dmag_o(dmag_c[k+1])
    );
  end

  sdiv_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_i  (ctl_c[DATA_WIDTH]),
    .quo_i  (quo_c[DATA_WIDTH]),
    .valid_o(out_valid),
    .quo_o  (out_quo)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.quotient = out_quo;
endmodule

[hw/rtl/sdiv_chk.sv]
// Port-level checks for the signed restoring divider, bound to the top level.
`timescale 1ns / 1ps

module sdiv_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_quotient
);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quotient))
    else $error("result word changed while stalled");

  // The input side is held off exactly when a result word waits untaken.
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // Nothing comes out right after reset if nothing was offered in between.
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 !in_valid |=> !out_valid)
    else $error("result word appeared without an accepted operand pair");

endmodule

bind signed_restoring_divider_core sdiv_chk #(.DATA_WIDTH(DATA_WIDTH)) u_sdiv_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_quotient(out_ch.quotient)
);

[bench/testbench.sv]
// Self-checking testbench for the pipelined signed restoring divider.
`timescale 1ns / 1ps

module testbench;

  localparam int DW         = 32;
  localparam int LATENCY    = DW + 2;
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_LEN   = 300;
  localparam int PHASE_LEN  = 150;
  localparam int N_DIRECTED = 21;
  localparam int PRINT_CAP  = 30;

  localparam logic signed [DW-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic        [DW-1:0] LSB_ONE = 32'd1;

  // One row of the directed table: operands, and the quotient where it is typed in.
  typedef struct {
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
    bit                   typed;
    logic signed [DW-1:0] quo;
  } div_case_t;

  div_case_t directed_cases [N_DIRECTED] = '{
    '{32'sd0,           32'sd1,   1'b1, 32'sd0},
    '{32'sd7,           32'sd2,   1'b1, 32'sd3},
    '{-32'sd7,          32'sd2,   1'b1, -32'sd3},
    '{32'sd7,           -32'sd2,  1'b1, -32'sd3},
    '{-32'sd7,          -32'sd2,  1'b1, 32'sd3},
    '{32'sd5,           32'sd0,   1'b1, Q_MAX},
    '{32'sd0,           32'sd0,   1'b1, Q_MAX},
    '{Q_MIN,            32'sd0,   1'b1, Q_MAX},
    '{-32'sd1,          32'sd0,   1'b1, Q_MAX},
    '{Q_MIN,            -32'sd1,  1'b1, Q_MAX},
    '{Q_MIN,            32'sd1,   1'b1, Q_MIN},
    '{Q_MAX,            32'sd1,   1'b1, Q_MAX},
    '{Q_MAX,            -32'sd1,  1'b1, -Q_MAX},
    '{Q_MIN,            Q_MIN,    1'b1, 32'sd1},
    '{Q_MAX,            Q_MIN,    1'b1, 32'sd0},
    '{Q_MIN,            Q_MAX,    1'b1, -32'sd1},
    '{32'sd1,           Q_MIN,    1'b1, 32'sd0},
    '{-32'sd1,          -32'sd1,  1'b1, 32'sd1},
    '{Q_MIN,            32'sd2,   1'b0, 32'sd0},
    '{32'sd100,         32'sd7,   1'b0, 32'sd0},
    '{-32'sd123456789,  32'sd1000, 1'b0, 32'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  sdiv_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  sdiv_out_if #(.DATA_WIDTH(DW)) out_ch ();

  signed_restoring_divider_core #(.DATA_WIDTH(DW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Quotients still owed by the block, oldest first.
  logic signed [DW-1:0] expected_quotients [$];

  int  err_count     = 0;
  int  words_sent    = 0;
  int  words_checked = 0;
  int  saturated     = 0;
  int  cycle_count   = 0;
  int  tx_idle_pct   = 0;
  int  rx_stall_pct  = 0;
  bit  hold_req      = 1'b0;
  logic hold_active  = 1'b0;

  always #2 clk = ~clk;

  // Truncating signed restoring division; zero divisor or overflow gives Q_MAX.
  function automatic logic signed [DW-1:0] divide_truncated(
    input logic signed [DW-1:0] dividend,
    input logic signed [DW-1:0] divisor
  );
    logic [DW-1:0] rem;
    logic [DW-1:0] mag_d;
    logic [DW-1:0] quo;
    logic          negate;
    if (divisor == '0 || (dividend == Q_MIN && divisor == -32'sd1)) begin
      return Q_MAX;
    end
    negate = dividend[DW-1] ^ divisor[DW-1];
    rem    = dividend[DW-1] ? ~dividend + LSB_ONE : dividend;
    mag_d  = divisor[DW-1] ? ~divisor + LSB_ONE : divisor;
    quo    = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      quo = quo << 1;
      if ((rem >> i) >= mag_d) begin
        quo[0] = 1'b1;
        rem    = rem - (mag_d << i);
      end
    end
    // A magnitude of 2^(DW-1) only arises as the most negative value.
    if (quo == Q_MIN) begin
      return Q_MIN;
    end
    if (negate) begin
      quo = ~quo + LSB_ONE;
    end
    return quo;
  endfunction

  // Operand mix: corner values, small and mid-sized numbers, and full-range words.
  function automatic logic signed [DW-1:0] random_operand();
    logic signed [DW-1:0] val;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: val = '0;
          1: val = 32'sd1;
          2: val = -32'sd1;
          3: val = Q_MIN;
          default: val = Q_MAX;
        endcase
      end
      1, 2: begin
        val = $urandom_range(255);
        if ($urandom_range(1)) val = -val;
      end
      3: begin
        val = $urandom_range(65535);
        if ($urandom_range(1)) val = -val;
      end
      default: val = $urandom();
    endcase
    return val;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [DW-1:0] got,
                                 input logic signed [DW-1:0] want);
    if (err_count < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s: got %0d (0x%08h), expected %0d (0x%08h)",
               cycle_count, what, got, got, want, want);
    end
    err_count++;
  endtask

  // Offer one word, with a random idle gap first, and record its quotient once taken.
  task automatic send_word(input logic signed [DW-1:0] num, input logic signed [DW-1:0] den,
                           input logic signed [DW-1:0] quo);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.numerator   <= num;
    in_ch.denominator <= den;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_quotients.push_back(quo);
    words_sent++;
    if (quo == Q_MAX && (den == '0 || num == Q_MIN)) saturated++;
  endtask

  // Result side: random stalls, overridden by the long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_active && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long hold-off on the result side, counted here so the row fills and stalls its input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Compare each quotient taken with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_quotients.size() == 0) begin
        report_mismatch("quotient with no word outstanding", out_ch.quotient, 'x);
      end else begin
        logic signed [DW-1:0] want;
        want = expected_quotients.pop_front();
        if (out_ch.quotient !== want) report_mismatch("quotient", out_ch.quotient, want);
        words_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles with %0d quotients outstanding",
               cycle_count, expected_quotients.size());
      $display("[signed_restoring_divider_core] ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.numerator   = '0;
    in_ch.denominator = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: corners, sign combinations and the saturating cases.
    foreach (directed_cases[i]) begin
      send_word(directed_cases[i].num, directed_cases[i].den,
                directed_cases[i].typed ? directed_cases[i].quo
                                        : divide_truncated(directed_cases[i].num,
                                                           directed_cases[i].den));
    end

    // Random words over four idling phases; the first also carries the long hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_req = 1'b1; end
        1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
        default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        num = random_operand();
        den = random_operand();
        send_word(num, den, divide_truncated(num, den));
      end
    end
    in_ch.valid <= 1'b0;

    // Drain the row, then allow a little more for any stray word.
    while (expected_quotients.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d operand pairs (%0d saturating) and checked %0d quotients,",
             words_sent, saturated, words_checked);
    $display("across free-running, sender-idle, receiver-stall, mixed and hold-off phases.");
    if (err_count == 0) begin
      $display("[signed_restoring_divider_core] OK");
    end else begin
      $display("[signed_restoring_divider_core] ERROR");
    end
    $finish;
  end

endmodule

[signed_restoring_divider_core.f]
hw/rtl/sdiv_pkg.sv
hw/rtl/sdiv_in_if.sv
hw/rtl/sdiv_out_if.sv
hw/rtl/sdiv_prep.sv
hw/rtl/sdiv_cell.sv
hw/rtl/sdiv_fix.sv
hw/rtl/signed_restoring_divider_core.sv
hw/rtl/sdiv_chk.sv
bench/testbench.sv
